// ===== rtl/gbfs_pkg.sv =====
package gbfs_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_MARK,
        ST_DEQ,
        ST_DIV,
        ST_QWAIT,
        ST_CALC,
        ST_NADDR,
        ST_NCHK,
        ST_TRRD,
        ST_TRCHK,
        ST_RESULT
    } state_t;

    // neighbour order and parent codes
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // input opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_MAP_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_MAP_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_VISIT_LIMIT = 2'd2;

    // widths fixed by the interface
    localparam int TILE_W  = 16;
    localparam int DIM_W   = 9;
    localparam int COORD_W = 8;
    localparam int LIMIT_W = 17;

    // query tag kept in the visited memory
    localparam int EPOCH_W = 8;

    // effective grid dimension: zero acts as one, above 256 acts as 256
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(256)) begin
            r = DIM_W'(256);
        end
        return r;
    endfunction

endpackage

// ===== rtl/grid_bfs_first_step_core.sv =====
// Breadth-first first-step finder over a row-major tile grid. A transaction with
// tuser 0 stores one passable bit; tuser 1 runs a query from tile_index
// to goal_tile and returns one result: the first tile of the path and a reachable
// flag. All search state sits in three single-port-write RAMs (passable map,
// visited tag plus parent direction, search queue), so a query first divides the
// start tile into column and row one bit a cycle, probes the start's neighbours,
// then for each node read from the queue compares it against the goal and probes
// its four neighbours through the one visited-RAM read port, then traces the
// path back from the goal step by step. A query with start equal to goal skips the search.
// Visited marks carry an 8-bit query tag; after reset, and before a searching
// query that finds the tag at its maximum, a clearing pass over all MAX_TILES
// entries runs while no input is taken (configuration writes are still accepted).
module grid_bfs_first_step_core #(
    parameter int MAX_TILES           = 65536,
    parameter int DEFAULT_VISIT_LIMIT = 1500
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // tile_index[15:0], passable[16], goal_tile[32:17], zero pad
    input  logic        s_tuser,   // opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // next_tile[15:0]
    output logic        m_tuser,   // reachable
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int AW   = $clog2(MAX_TILES);
    localparam int CW   = AW + 2;
    localparam int LW   = (CW > gbfs_pkg::LIMIT_W) ? CW : gbfs_pkg::LIMIT_W;
    localparam int TW   = gbfs_pkg::TILE_W;
    localparam int DW   = gbfs_pkg::DIM_W;
    localparam int XW   = gbfs_pkg::COORD_W;
    localparam int EW   = gbfs_pkg::EPOCH_W;
    localparam int VW   = EW + 2;

    gbfs_pkg::state_t state_reg, state_next;

    // configuration
    logic [DW-1:0]               w_cfg_reg, h_cfg_reg;
    logic [gbfs_pkg::LIMIT_W-1:0] lim_reg;
    logic [DW-1:0]               w_eff, h_eff;

    // control
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          clr_all_reg, clr_all_next;
    logic          pend_reg, pend_next;
    logic [EW-1:0] epoch_reg, epoch_next;
    logic [CW-1:0] hd_reg, hd_next;
    logic [CW-1:0] qcnt_reg, qcnt_next;
    logic [1:0]    dir_reg, dir_next;
    logic          m_valid_reg, m_valid_next;

    // payload
    logic [TW-1:0] start_reg, start_next;
    logic [TW-1:0] goal_reg, goal_next;
    logic [XW-1:0] cx_reg, cx_next;
    logic [TW-1:0] cy_reg, cy_next;
    logic [AW-1:0] nt_reg, nt_next;
    logic [XW-1:0] nx_reg, nx_next;
    logic [XW-1:0] ny_reg, ny_next;
    logic          nok_reg, nok_next;
    logic [TW-1:0] at_reg, at_next;
    logic [TW-1:0] res_tile_reg, res_tile_next;
    logic          res_reach_reg, res_reach_next;
    logic [TW-1:0] m_data_reg, m_data_next;
    logic          m_user_reg, m_user_next;

    // input fields
    logic          in_op, in_pass;
    logic [TW-1:0] in_tile, in_goal;
    logic          in_acc;

    // memories
    logic          pm_we, pm_wdata, pm_rdata;
    logic [AW-1:0] pm_waddr, pm_raddr;
    logic          vm_we;
    logic [VW-1:0] vm_wdata, vm_rdata;
    logic [AW-1:0] vm_waddr, vm_raddr;
    logic          qm_we;
    logic [TW-1:0] qm_wdata, qm_rdata;
    logic [AW-1:0] qm_waddr, qm_raddr;

    // divider
    logic          div_start, div_done;
    logic [TW-1:0] div_quot;
    logic [XW-1:0] div_rem;

    // shared conditions
    logic                 deq_ok, cur_hit, take, clr_last, start_in, epoch_full;
    logic [TW:0]          cur_idx;
    logic                 cand_ok;
    logic [XW-1:0]        cand_x, cand_y;
    logic [2*DW:0]        cand_idx;
    logic [TW:0]          par;
    logic                 par_hit, at_out;
    logic [TW:0]          cy_ext;

    assign in_op   = s_tuser;
    assign in_tile = s_tdata[15:0];
    assign in_pass = s_tdata[16];
    assign in_goal = s_tdata[32:17];
    assign in_acc  = s_tvalid && s_tready;

    assign w_eff = gbfs_pkg::clamp_dim(w_cfg_reg);
    assign h_eff = gbfs_pkg::clamp_dim(h_cfg_reg);

    assign s_tready  = (state_reg == gbfs_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    // queue not empty and visit budget left
    assign deq_ok = (LW'(hd_reg) <= LW'(qcnt_reg)) && (LW'(hd_reg) < LW'(lim_reg));
    assign clr_last   = (clr_addr_reg == AW'(MAX_TILES - 1));
    assign start_in   = ({1'b0, start_reg} < (TW+1)'(MAX_TILES));
    assign epoch_full = (epoch_reg == '1);

    // tile index of a dequeued queue entry
    assign cur_idx = (TW+1)'(cy_reg[DW-1:0] * w_eff) + (TW+1)'(cx_reg);
    assign cur_hit = (cur_idx == {1'b0, goal_reg});

    // neighbour candidate for the current direction
    assign cy_ext = {1'b0, cy_reg};
    always_comb begin
        cand_ok = 1'b0;
        cand_x  = cx_reg;
        cand_y  = cy_reg[XW-1:0];
        case (dir_reg)
            gbfs_pkg::DIR_UP: begin
                cand_ok = (cy_reg != '0) && ((cy_ext - (TW+1)'(1)) < (TW+1)'(h_eff));
                cand_y  = XW'(cy_reg - TW'(1));
            end
            gbfs_pkg::DIR_DOWN: begin
                cand_ok = ((cy_ext + (TW+1)'(1)) < (TW+1)'(h_eff));
                cand_y  = XW'(cy_reg + TW'(1));
            end
            gbfs_pkg::DIR_LEFT: begin
                cand_ok = (cx_reg != '0) && (cy_ext < (TW+1)'(h_eff));
                cand_x  = cx_reg - XW'(1);
            end
            gbfs_pkg::DIR_RIGHT: begin
                cand_ok = ((DW'(cx_reg) + DW'(1)) < w_eff) && (cy_ext < (TW+1)'(h_eff));
                cand_x  = cx_reg + XW'(1);
            end
            default: begin
                cand_ok = 1'b0;
            end
        endcase
    end
    assign cand_idx = (2*DW+1)'(DW'(cand_y) * w_eff) + (2*DW+1)'(cand_x);

    // neighbour is taken when passable, not yet tagged this query and queue has room
    assign take = nok_reg && pm_rdata && (vm_rdata[VW-1:2] != epoch_reg)
                  && (qcnt_reg < CW'(MAX_TILES));

    // parent of the traced tile
    always_comb begin
        case (vm_rdata[1:0])
            gbfs_pkg::DIR_UP:    par = {1'b0, at_reg} + (TW+1)'(w_eff);
            gbfs_pkg::DIR_DOWN:  par = {1'b0, at_reg} - (TW+1)'(w_eff);
            gbfs_pkg::DIR_LEFT:  par = {1'b0, at_reg} + (TW+1)'(1);
            gbfs_pkg::DIR_RIGHT: par = {1'b0, at_reg} - (TW+1)'(1);
            default:             par = {1'b0, at_reg};
        endcase
    end
    assign par_hit = (par == {1'b0, start_reg});
    assign at_out  = ({1'b0, at_reg} >= (TW+1)'(MAX_TILES));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gbfs_pkg::ST_CLR: begin
                if (clr_last) begin
                    state_next = pend_reg ? gbfs_pkg::ST_MARK : gbfs_pkg::ST_IDLE;
                end
            end
            gbfs_pkg::ST_IDLE: begin
                if (in_acc && in_op == gbfs_pkg::OP_QUERY) begin
                    if (in_tile == in_goal) begin
                        state_next = gbfs_pkg::ST_RESULT;
                    end else if (epoch_full) begin
                        state_next = gbfs_pkg::ST_CLR;
                    end else begin
                        state_next = gbfs_pkg::ST_MARK;
                    end
                end
            end
            gbfs_pkg::ST_MARK: state_next = gbfs_pkg::ST_DEQ;
            gbfs_pkg::ST_DEQ: begin
                if (!deq_ok) begin
                    state_next = gbfs_pkg::ST_RESULT;
                end else if (hd_reg == '0) begin
                    state_next = gbfs_pkg::ST_DIV;
                end else begin
                    state_next = gbfs_pkg::ST_QWAIT;
                end
            end
            gbfs_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = gbfs_pkg::ST_NADDR;
                end
            end
            gbfs_pkg::ST_QWAIT: state_next = gbfs_pkg::ST_CALC;
            gbfs_pkg::ST_CALC: begin
                state_next = cur_hit ? gbfs_pkg::ST_TRRD : gbfs_pkg::ST_NADDR;
            end
            gbfs_pkg::ST_NADDR: state_next = gbfs_pkg::ST_NCHK;
            gbfs_pkg::ST_NCHK: begin
                state_next = (dir_reg == gbfs_pkg::DIR_RIGHT) ? gbfs_pkg::ST_DEQ
                                                               : gbfs_pkg::ST_NADDR;
            end
            gbfs_pkg::ST_TRRD: begin
                state_next = at_out ? gbfs_pkg::ST_RESULT : gbfs_pkg::ST_TRCHK;
            end
            gbfs_pkg::ST_TRCHK: begin
                state_next = par_hit ? gbfs_pkg::ST_RESULT : gbfs_pkg::ST_TRRD;
            end
            gbfs_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = gbfs_pkg::ST_IDLE;
                end
            end
            default: state_next = gbfs_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        clr_addr_next  = clr_addr_reg;
        clr_all_next   = clr_all_reg;
        pend_next      = pend_reg;
        epoch_next     = epoch_reg;
        hd_next        = hd_reg;
        qcnt_next      = qcnt_reg;
        dir_next       = dir_reg;
        start_next     = start_reg;
        goal_next      = goal_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        nt_next        = nt_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        nok_next       = nok_reg;
        at_next        = at_reg;
        res_tile_next  = res_tile_reg;
        res_reach_next = res_reach_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        m_valid_next   = m_valid_reg && !m_tready;

        pm_we    = 1'b0;
        pm_waddr = in_tile[AW-1:0];
        pm_wdata = in_pass;
        pm_raddr = cand_idx[AW-1:0];
        vm_we    = 1'b0;
        vm_waddr = nt_reg;
        vm_wdata = {epoch_reg, dir_reg};
        vm_raddr = cand_idx[AW-1:0];
        qm_we    = 1'b0;
        qm_waddr = qcnt_reg[AW-1:0];
        qm_wdata = {ny_reg, nx_reg};
        qm_raddr = AW'(hd_reg - CW'(1));
        div_start = 1'b0;

        case (state_reg)
            // sweep through the visited memory, and the map after reset
            gbfs_pkg::ST_CLR: begin
                vm_we    = 1'b1;
                vm_waddr = clr_addr_reg;
                vm_wdata = '0;
                pm_we    = clr_all_reg;
                pm_waddr = clr_addr_reg;
                pm_wdata = 1'b0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_last) begin
                    clr_all_next = 1'b0;
                    pend_next    = 1'b0;
                    epoch_next   = pend_reg ? EW'(1) : '0;
                end
            end
            gbfs_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (in_op == gbfs_pkg::OP_WRITE) begin
                        pm_we = ({1'b0, in_tile} < (TW+1)'(MAX_TILES));
                    end else begin
                        start_next = in_tile;
                        goal_next  = in_goal;
                        hd_next    = '0;
                        qcnt_next  = '0;
                        if (in_tile == in_goal) begin
                            res_tile_next  = in_tile;
                            res_reach_next = 1'b1;
                        end else if (epoch_full) begin
                            pend_next = 1'b1;
                        end else begin
                            epoch_next = epoch_reg + EW'(1);
                        end
                    end
                end
            end
            // tag the start tile and split it into column and row
            gbfs_pkg::ST_MARK: begin
                vm_we     = start_in;
                vm_waddr  = start_reg[AW-1:0];
                vm_wdata  = {epoch_reg, gbfs_pkg::DIR_UP};
                div_start = 1'b1;
            end
            gbfs_pkg::ST_DEQ: begin
                if (!deq_ok) begin
                    res_tile_next  = '0;
                    res_reach_next = 1'b0;
                end
            end
            gbfs_pkg::ST_DIV: begin
                if (div_done) begin
                    cx_next  = div_rem;
                    cy_next  = div_quot;
                    hd_next  = CW'(1);
                    dir_next = gbfs_pkg::DIR_UP;
                end
            end
            gbfs_pkg::ST_QWAIT: begin
                cx_next  = qm_rdata[XW-1:0];
                cy_next  = TW'(qm_rdata[TW-1:XW]);
                hd_next  = hd_reg + CW'(1);
                dir_next = gbfs_pkg::DIR_UP;
            end
            gbfs_pkg::ST_CALC: begin
                at_next = goal_reg;
            end
            // probe one neighbour
            gbfs_pkg::ST_NADDR: begin
                nt_next  = cand_idx[AW-1:0];
                nx_next  = cand_x;
                ny_next  = cand_y;
                nok_next = cand_ok && (cand_idx < (2*DW+1)'(MAX_TILES));
            end
            gbfs_pkg::ST_NCHK: begin
                if (take) begin
                    vm_we     = 1'b1;
                    qm_we     = 1'b1;
                    qcnt_next = qcnt_reg + CW'(1);
                end
                dir_next = dir_reg + 2'd1;
            end
            // walk parent links back towards the start
            gbfs_pkg::ST_TRRD: begin
                vm_raddr = at_reg[AW-1:0];
                if (at_out) begin
                    res_tile_next  = at_reg;
                    res_reach_next = 1'b1;
                end
            end
            gbfs_pkg::ST_TRCHK: begin
                if (par_hit) begin
                    res_tile_next  = at_reg;
                    res_reach_next = 1'b1;
                end else begin
                    at_next = par[TW-1:0];
                end
            end
            gbfs_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_tile_reg;
                    m_user_next  = res_reach_reg;
                end
            end
            default: begin
                pm_we = 1'b0;
            end
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= gbfs_pkg::ST_CLR;
            clr_addr_reg <= '0;
            clr_all_reg  <= 1'b1;
            pend_reg     <= 1'b0;
            epoch_reg    <= '0;
            hd_reg       <= '0;
            qcnt_reg     <= '0;
            dir_reg      <= gbfs_pkg::DIR_UP;
            m_valid_reg  <= 1'b0;
            w_cfg_reg    <= DW'(256);
            h_cfg_reg    <= DW'(256);
            lim_reg      <= gbfs_pkg::LIMIT_W'(DEFAULT_VISIT_LIMIT);
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            clr_all_reg  <= clr_all_next;
            pend_reg     <= pend_next;
            epoch_reg    <= epoch_next;
            hd_reg       <= hd_next;
            qcnt_reg     <= qcnt_next;
            dir_reg      <= dir_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    gbfs_pkg::CFG_MAP_WIDTH:   w_cfg_reg <= cfg_data[DW-1:0];
                    gbfs_pkg::CFG_MAP_HEIGHT:  h_cfg_reg <= cfg_data[DW-1:0];
                    gbfs_pkg::CFG_VISIT_LIMIT: lim_reg   <= cfg_data;
                    default: begin
                        lim_reg <= lim_reg;
                    end
                endcase
            end
        end
        start_reg     <= start_next;
        goal_reg      <= goal_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        nt_reg        <= nt_next;
        nx_reg        <= nx_next;
        ny_reg        <= ny_next;
        nok_reg       <= nok_next;
        at_reg        <= at_next;
        res_tile_reg  <= res_tile_next;
        res_reach_reg <= res_reach_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    // passable map
    gbfs_ram #(.WIDTH(1), .DEPTH(MAX_TILES)) u_pass_ram (
        .aclk  (aclk),
        .we    (pm_we),
        .waddr (pm_waddr),
        .wdata (pm_wdata),
        .raddr (pm_raddr),
        .rdata (pm_rdata)
    );

    // visited tag and parent direction
    gbfs_ram #(.WIDTH(VW), .DEPTH(MAX_TILES)) u_visit_ram (
        .aclk  (aclk),
        .we    (vm_we),
        .waddr (vm_waddr),
        .wdata (vm_wdata),
        .raddr (vm_raddr),
        .rdata (vm_rdata)
    );

    // search queue of row and column pairs
    gbfs_ram #(.WIDTH(TW), .DEPTH(MAX_TILES)) u_queue_ram (
        .aclk  (aclk),
        .we    (qm_we),
        .waddr (qm_waddr),
        .wdata (qm_wdata),
        .raddr (qm_raddr),
        .rdata (qm_rdata)
    );

    // start tile to column and row
    gbfs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (start_reg),
        .divisor  (w_eff),
        .quot     (div_quot),
        .rem      (div_rem),
        .done     (div_done)
    );

endmodule

// ===== rtl/gbfs_ram.sv =====
module gbfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/gbfs_div.sv =====
module gbfs_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [gbfs_pkg::TILE_W-1:0]    dividend,
    input  logic [gbfs_pkg::DIM_W-1:0]     divisor,
    output logic [gbfs_pkg::TILE_W-1:0]    quot,
    output logic [gbfs_pkg::COORD_W-1:0]   rem,
    output logic                           done
);

    localparam int CNT_W = $clog2(gbfs_pkg::TILE_W + 1);

    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [gbfs_pkg::TILE_W-1:0]     q_reg, q_next;
    logic [gbfs_pkg::DIM_W:0]        r_reg, r_next;
    logic [gbfs_pkg::DIM_W-1:0]      d_reg, d_next;
    logic [gbfs_pkg::DIM_W:0]        trial;

    // one quotient bit per cycle, restoring
    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        trial     = {r_reg[gbfs_pkg::DIM_W-1:0], q_reg[gbfs_pkg::TILE_W-1]};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[gbfs_pkg::TILE_W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[gbfs_pkg::TILE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(gbfs_pkg::TILE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quot = q_reg;
    assign rem  = r_reg[gbfs_pkg::COORD_W-1:0];
    assign done = done_reg;

endmodule

// ===== tb/sv/grid_bfs_first_step_core_tb.sv =====
module grid_bfs_first_step_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TILES     = 65536;
    localparam int IDLE_LIMIT    = 2_000_000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic        opcode;
        logic [15:0] tile_index;
        logic        passable;
        logic [15:0] goal_tile;
    } tile_op_t;

    typedef struct packed {
        logic [15:0] next_tile;
        logic        reachable;
    } first_step_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // tile_index[15:0], passable[16], goal_tile[32:17], zero pad
    logic        s_tuser;   // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // next_tile[15:0]
    logic        m_tuser;   // reachable
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;

    grid_bfs_first_step_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state: map, search scratch and register copies
    bit          tile_open [NUM_TILES];
    bit          tile_seen [NUM_TILES];
    logic [1:0]  came_from [NUM_TILES];
    int          frontier  [NUM_TILES + 1];
    logic [8:0]  grid_cols;
    logic [8:0]  grid_rows;
    logic [16:0] node_budget;

    tile_op_t    pending_ops[$];
    first_step_t expected_steps[$];

    bit s_fire;
    bit m_fire;
    int s_gap;
    int m_wait;
    bit s_burst;
    bit m_burst;
    int idle_cycles;
    int fail_count;
    int n_writes;
    int n_queries;
    int n_found;

    function automatic int eff_dim(logic [8:0] v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return int'(v);
    endfunction

    function automatic int move_dx(logic [1:0] d);
        case (d)
            gbfs_pkg::DIR_LEFT:  return -1;
            gbfs_pkg::DIR_RIGHT: return 1;
            default:             return 0;
        endcase
    endfunction

    function automatic int move_dy(logic [1:0] d);
        case (d)
            gbfs_pkg::DIR_UP:   return -1;
            gbfs_pkg::DIR_DOWN: return 1;
            default:            return 0;
        endcase
    endfunction

    // breadth-first search from start, trace parents back from the goal
    function automatic first_step_t find_first_step(int start, int goal);
        first_step_t r;
        int w;
        int h;
        int head;
        int tail;
        int visits;
        int cur;
        int nx;
        int ny;
        int nt;
        int at;
        int par;
        w = eff_dim(grid_cols);
        h = eff_dim(grid_rows);
        r = '0;
        if (start == goal) begin
            r.next_tile = start[15:0];
            r.reachable = 1'b1;
            return r;
        end
        foreach (tile_seen[i]) tile_seen[i] = 1'b0;
        head = 0;
        tail = 0;
        visits = 0;
        frontier[tail++] = start;
        tile_seen[start] = 1'b1;
        while (head < tail && visits < int'(node_budget)) begin
            cur = frontier[head++];
            visits++;
            if (cur == goal) begin
                at = goal;
                for (int g = 0; g <= NUM_TILES; g++) begin
                    par = at - move_dy(came_from[at]) * w - move_dx(came_from[at]);
                    if (par == start) break;
                    at = par;
                end
                r.next_tile = at[15:0];
                r.reachable = 1'b1;
                return r;
            end
            for (int d = 0; d < 4; d++) begin
                nx = cur % w + move_dx(d[1:0]);
                ny = cur / w + move_dy(d[1:0]);
                if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
                nt = ny * w + nx;
                if (nt >= NUM_TILES) continue;
                if (!tile_open[nt] || tile_seen[nt]) continue;
                tile_seen[nt] = 1'b1;
                came_from[nt] = d[1:0];
                frontier[tail++] = nt;
            end
        end
        return r;
    endfunction

    function automatic int draw_gap(bit burst);
        if (burst) return 0;
        return $urandom_range(0, 14);
    endfunction

    // input driver: next transaction from the pending queue after a random gap
    always @(negedge aclk) begin
        tile_op_t op;
        if (aresetn && (!s_tvalid || s_fire)) begin
            if (s_gap > 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                op = pending_ops.pop_front();
                s_tdata  <= {7'b0, op.goal_tile, op.passable, op.tile_index};
                s_tuser  <= op.opcode;
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 19) == 0) s_burst = !s_burst;
                s_gap = draw_gap(s_burst);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure: random stall before each result
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_fire) begin
                if ($urandom_range(0, 9) == 0) m_burst = !m_burst;
                m_wait = draw_gap(m_burst);
                m_tready <= (m_wait == 0);
            end else if (m_wait > 0) begin
                m_wait--;
                m_tready <= (m_wait == 0);
            end
        end
    end

    // monitor: predict on accepted inputs, check accepted results
    always @(posedge aclk) begin
        first_step_t got;
        first_step_t want;
        s_fire = aresetn && s_tvalid && s_tready;
        m_fire = aresetn && m_tvalid && m_tready;
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                gbfs_pkg::CFG_MAP_WIDTH:   grid_cols   = cfg_data[8:0];
                gbfs_pkg::CFG_MAP_HEIGHT:  grid_rows   = cfg_data[8:0];
                gbfs_pkg::CFG_VISIT_LIMIT: node_budget = cfg_data;
                default: ;
            endcase
        end
        if (s_fire) begin
            if (s_tuser == gbfs_pkg::OP_WRITE) begin
                tile_open[s_tdata[15:0]] = s_tdata[16];
                n_writes++;
            end else begin
                want = find_first_step(int'(s_tdata[15:0]), int'(s_tdata[32:17]));
                expected_steps = {expected_steps, want};
                n_queries++;
                if (want.reachable) n_found++;
            end
        end
        if (m_fire) begin
            got.next_tile = m_tdata;
            got.reachable = m_tuser;
            if (expected_steps.size() == 0) begin
                $error("result with nothing expected: next_tile %0d reachable %0d",
                       got.next_tile, got.reachable);
                fail_count++;
            end else begin
                want = expected_steps.pop_front();
                if (got.next_tile !== want.next_tile) begin
                    $error("next_tile: expected %0d, actual %0d", want.next_tile,
                           got.next_tile);
                    fail_count++;
                end
                if (got.reachable !== want.reachable) begin
                    $error("reachable: expected %0d, actual %0d", want.reachable,
                           got.reachable);
                    fail_count++;
                end
            end
        end
        // watchdog on cycles without any transaction
        if (s_fire || m_fire || (cfg_valid && cfg_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", expected_steps.size());
            $display("grid_bfs_first_step_core_tb: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(logic [8:0] cols, logic [8:0] rows, logic [16:0] budget);
        write_reg(gbfs_pkg::CFG_MAP_WIDTH, {8'b0, cols});
        write_reg(gbfs_pkg::CFG_MAP_HEIGHT, {8'b0, rows});
        write_reg(gbfs_pkg::CFG_VISIT_LIMIT, budget);
    endtask

    task automatic push_op(logic opc, int tile, logic pass, int goal);
        tile_op_t op;
        op.opcode     = opc;
        op.tile_index = tile[15:0];
        op.passable   = pass;
        op.goal_tile  = goal[15:0];
        pending_ops = {pending_ops, op};
    endtask

    // wait until every transaction is accepted and every result is back
    task automatic drain();
        do @(posedge aclk);
        while (pending_ops.size() > 0 || s_tvalid || expected_steps.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic int pick_tile(int span);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
        return $urandom_range(0, span - 1);
    endfunction

    // mostly writes that open tiles, with queries mixed in
    task automatic random_ops(int n, int span);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 35)
                push_op(gbfs_pkg::OP_QUERY, pick_tile(span), 1'($urandom_range(0, 1)),
                        pick_tile(span));
            else
                push_op(gbfs_pkg::OP_WRITE, pick_tile(span), $urandom_range(0, 3) != 0,
                        pick_tile(span));
        end
    endtask

    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_gap = 0;
        m_wait = 0;
        s_burst = 1'b0;
        m_burst = 1'b0;
        idle_cycles = 0;
        fail_count = 0;
        n_writes = 0;
        n_queries = 0;
        n_found = 0;
        grid_cols = 9'd256;
        grid_rows = 9'd256;
        node_budget = 17'd1500;
        foreach (tile_open[i]) tile_open[i] = 1'b0;
        foreach (came_from[i]) came_from[i] = gbfs_pkg::DIR_UP;
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn  <= 1'b1;
        m_tready <= 1'b1;

        // default registers: corner tiles, start equals goal, blocked start and goal
        push_op(gbfs_pkg::OP_WRITE, 0, 1'b1, 0);
        push_op(gbfs_pkg::OP_WRITE, 1, 1'b1, 65535);
        push_op(gbfs_pkg::OP_WRITE, 65535, 1'b1, 0);
        push_op(gbfs_pkg::OP_WRITE, 65534, 1'b1, 43690);
        push_op(gbfs_pkg::OP_WRITE, 256, 1'b0, 21845);
        push_op(gbfs_pkg::OP_QUERY, 0, 1'b0, 0);
        push_op(gbfs_pkg::OP_QUERY, 0, 1'b1, 1);
        push_op(gbfs_pkg::OP_QUERY, 65535, 1'b0, 65534);
        push_op(gbfs_pkg::OP_QUERY, 0, 1'b0, 256);
        push_op(gbfs_pkg::OP_QUERY, 65535, 1'b0, 0);
        push_op(gbfs_pkg::OP_QUERY, 2, 1'b0, 1);
        drain();

        // zero visit budget never dequeues anything
        set_grid(9'd256, 9'd256, 17'd0);
        push_op(gbfs_pkg::OP_QUERY, 0, 1'b0, 1);
        push_op(gbfs_pkg::OP_QUERY, 7, 1'b0, 7);
        drain();

        // tiny grid, full budget, start below the last row
        set_grid(9'd5, 9'd4, 17'h1FFFF);
        push_op(gbfs_pkg::OP_WRITE, 17, 1'b1, 0);
        push_op(gbfs_pkg::OP_WRITE, 12, 1'b1, 0);
        push_op(gbfs_pkg::OP_QUERY, 22, 1'b0, 12);
        push_op(gbfs_pkg::OP_QUERY, 40, 1'b0, 12);
        random_ops(30, 25);
        drain();

        // width zero acts as a single column, height above range acts as 256
        set_grid(9'd0, 9'd511, 17'd65536);
        random_ops(30, 300);
        drain();

        // small budget so many searches run out
        set_grid(9'd16, 9'd16, 17'd20);
        random_ops(30, 256);
        drain();

        // full size grid with the default budget
        set_grid(9'd256, 9'd256, 17'd1500);
        random_ops(35, 2048);
        drain();

        // budget of one node on a wide, flat grid
        set_grid(9'd300, 9'd3, 17'd1);
        random_ops(12, 900);
        drain();

        $display("covered %0d map writes and %0d queries (%0d reachable) over seven",
                 n_writes, n_queries, n_found);
        $display("grid and budget settings including zero and out of range values");
        if (fail_count == 0) begin
            $display("grid_bfs_first_step_core_tb: PASS");
        end else begin
            $display("grid_bfs_first_step_core_tb: FAIL");
        end
        $finish;
    end

endmodule
